FILE: rtl/core/vkc_pkg.sv
// ----------------------------------------------------------------------------
// vkc_pkg: shared types, codes and the glyph table of the key composer
// Holds the sequencer states, input kinds, diacritic and letter codes, and the
// function that maps a stored letter to its code point.
// ----------------------------------------------------------------------------
package vkc_pkg;

    localparam int MAX_LETTERS_DEF = 16;
    localparam int ENTRY_W         = 14;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [2:0] DIA_NONE   = 3'd0;
    localparam logic [2:0] DIA_CIRC   = 3'd1;
    localparam logic [2:0] DIA_BREVE  = 3'd2;
    localparam logic [2:0] DIA_HORN   = 3'd3;
    localparam logic [2:0] DIA_STROKE = 3'd4;

    localparam logic [2:0] TONE_LAST = 3'd5;

    localparam logic [6:0] CH_0  = 7'h30;
    localparam logic [6:0] CH_5  = 7'h35;
    localparam logic [6:0] CH_6  = 7'h36;
    localparam logic [6:0] CH_7  = 7'h37;
    localparam logic [6:0] CH_8  = 7'h38;
    localparam logic [6:0] CH_9  = 7'h39;
    localparam logic [6:0] CH_UA = 7'h41;
    localparam logic [6:0] CH_UU = 7'h55;
    localparam logic [6:0] CH_UZ = 7'h5a;
    localparam logic [6:0] CH_A  = 7'h61;
    localparam logic [6:0] CH_D  = 7'h64;
    localparam logic [6:0] CH_E  = 7'h65;
    localparam logic [6:0] CH_F  = 7'h66;
    localparam logic [6:0] CH_I  = 7'h69;
    localparam logic [6:0] CH_J  = 7'h6a;
    localparam logic [6:0] CH_O  = 7'h6f;
    localparam logic [6:0] CH_Q  = 7'h71;
    localparam logic [6:0] CH_R  = 7'h72;
    localparam logic [6:0] CH_S  = 7'h73;
    localparam logic [6:0] CH_U  = 7'h75;
    localparam logic [6:0] CH_W  = 7'h77;
    localparam logic [6:0] CH_X  = 7'h78;
    localparam logic [6:0] CH_Y  = 7'h79;
    localparam logic [6:0] CH_Z  = 7'h7a;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_MOD_RD,
        S_MOD_WR,
        S_PUSH,
        S_EMIT_RD,
        S_EMIT_CV,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MOD_SET_DIA,
        MOD_TGL_DIA,
        MOD_TGL_TONE
    } mod_op_t;

    // lowercase code points; uppercase is one below (above 0xff) or 0x20 below
    localparam logic [15:0] GLYPH_LO [0:12][0:5] = '{
        '{16'h0061, 16'h00e1, 16'h00e0, 16'h1ea3, 16'h00e3, 16'h1ea1},
        '{16'h00e2, 16'h1ea5, 16'h1ea7, 16'h1ea9, 16'h1eab, 16'h1ead},
        '{16'h0103, 16'h1eaf, 16'h1eb1, 16'h1eb3, 16'h1eb5, 16'h1eb7},
        '{16'h0065, 16'h00e9, 16'h00e8, 16'h1ebb, 16'h1ebd, 16'h1eb9},
        '{16'h00ea, 16'h1ebf, 16'h1ec1, 16'h1ec3, 16'h1ec5, 16'h1ec7},
        '{16'h0069, 16'h00ed, 16'h00ec, 16'h1ec9, 16'h0129, 16'h1ecb},
        '{16'h006f, 16'h00f3, 16'h00f2, 16'h1ecf, 16'h00f5, 16'h1ecd},
        '{16'h00f4, 16'h1ed1, 16'h1ed3, 16'h1ed5, 16'h1ed7, 16'h1ed9},
        '{16'h01a1, 16'h1edb, 16'h1edd, 16'h1edf, 16'h1ee1, 16'h1ee3},
        '{16'h0075, 16'h00fa, 16'h00f9, 16'h1ee7, 16'h0169, 16'h1ee5},
        '{16'h01b0, 16'h1ee9, 16'h1eeb, 16'h1eed, 16'h1eef, 16'h1ef1},
        '{16'h0079, 16'h00fd, 16'h1ef3, 16'h1ef7, 16'h1ef9, 16'h1ef5},
        '{16'h0111, 16'h0111, 16'h0111, 16'h0111, 16'h0111, 16'h0111}
    };

    function automatic logic is_upper(input logic [6:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic [6:0] to_low(input logic [6:0] c);
        return is_upper(c) ? (c + 7'h20) : c;
    endfunction

    function automatic logic is_alpha(input logic [6:0] c);
        logic [6:0] l;
        l = to_low(c);
        return (l >= CH_A) && (l <= CH_Z);
    endfunction

    function automatic logic is_vowel(input logic [6:0] c);
        logic [6:0] l;
        l = to_low(c);
        return (l == CH_A) || (l == CH_E) || (l == CH_I) || (l == CH_O) ||
               (l == CH_U) || (l == CH_Y);
    endfunction

    function automatic logic [15:0] glyph_code(input logic [6:0] b, input logic [2:0] d,
                                               input logic [2:0] t);
        logic [6:0]  lb;
        logic        hit;
        logic [3:0]  row;
        logic [15:0] lo;
        logic [15:0] res;
        lb  = to_low(b);
        hit = 1'b1;
        row = 4'd0;
        case ({lb, d})
            {CH_A, DIA_NONE}:   row = 4'd0;
            {CH_A, DIA_CIRC}:   row = 4'd1;
            {CH_A, DIA_BREVE}:  row = 4'd2;
            {CH_E, DIA_NONE}:   row = 4'd3;
            {CH_E, DIA_CIRC}:   row = 4'd4;
            {CH_I, DIA_NONE}:   row = 4'd5;
            {CH_O, DIA_NONE}:   row = 4'd6;
            {CH_O, DIA_CIRC}:   row = 4'd7;
            {CH_O, DIA_HORN}:   row = 4'd8;
            {CH_U, DIA_NONE}:   row = 4'd9;
            {CH_U, DIA_HORN}:   row = 4'd10;
            {CH_Y, DIA_NONE}:   row = 4'd11;
            {CH_D, DIA_STROKE}: row = 4'd12;
            default:            hit = 1'b0;
        endcase
        res = {9'd0, b};
        if (hit && (t <= TONE_LAST)) begin
            lo = GLYPH_LO[row][t];
            if (!is_upper(b))
                res = lo;
            else if (lo < 16'h0100)
                res = lo - 16'h0020;
            else
                res = lo - 16'h0001;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/vietnamese_key_composer_core.sv
// ----------------------------------------------------------------------------
// vietnamese_key_composer_core: Telex / VNI syllable composer
// Builds one syllable from ASCII keystrokes and emits it as code points.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command word: s_tuser is the kind (key, read, commit,
//   clear), s_tdata the ASCII key. m_* returns result words: one word for a
//   key or a clear, one word per held letter for read and commit (a single
//   word when the buffer is empty), with m_tlast on the final word.
//   cfg_we/cfg_wdata set the input method (0 Telex, 1 VNI) while idle.
// Sequence:
//   A key scans each held letter (read the letter RAM, then evaluate), with
//   no scan on an empty buffer, then decides, then does a read-modify-write
//   of the target letter and an append where the decision asks for them,
//   and then presents the result word. Read and commit go through each
//   letter in turn (RAM read, glyph lookup, output), and each output word
//   waits while m_tready is low. The single RAM read port sets this order.
//   s_tready is high only between items.
// Reset and stall:
//   rst_n clears the letter count, the method and the sequencer; letter RAM
//   contents are not cleared, only entries below the count are read. While
//   m_tready is low the result word holds and nothing advances.
// ----------------------------------------------------------------------------
module vietnamese_key_composer_core #(
    parameter int MAX_LETTERS = vkc_pkg::MAX_LETTERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] key_code, [7] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] accepted, [16:1] code_point,
                                   // [21:17] letter_count, [23:22] zero
    output logic        m_tlast
);
    import vkc_pkg::*;

    localparam int IW = $clog2(MAX_LETTERS);
    localparam int CW = $clog2(MAX_LETTERS + 1);

    state_t state_reg, state_next;

    logic          method_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] emit_n_reg;
    logic [1:0]    kind_reg;
    logic [6:0]    key_reg;

    // scan summary
    logic [1:0]    vcnt_reg;
    logic [IW-1:0] pos0_reg, pos1_reg, posl_reg;
    logic          mk_v_reg;
    logic [IW-1:0] mk_idx_reg;
    logic          fc_reg, qu_reg;
    logic [6:0]    prev_low_reg;
    logic          w_v_reg;
    logic [IW-1:0] w_idx_reg;
    logic [2:0]    w_dia_reg;
    logic          circ_v_reg, horn_v_reg, brev_v_reg, dd_v_reg;
    logic [IW-1:0] circ_idx_reg, horn_idx_reg, brev_idx_reg, dd_idx_reg;
    logic [6:0]    last_base_reg;
    logic [2:0]    last_dia_reg;

    // decision
    logic          mod_en_reg, push_en_reg;
    logic [IW-1:0] mod_idx_reg;
    mod_op_t       mod_op_reg;
    logic [2:0]    mod_val_reg;
    logic [6:0]    push_base_reg;
    logic [2:0]    push_dia_reg;

    logic          d_acc, d_mod_en, d_push_en;
    logic [IW-1:0] d_mod_idx;
    mod_op_t       d_mod_op;
    logic [2:0]    d_mod_val;
    logic [6:0]    d_push_base;
    logic [2:0]    d_push_dia;

    // result word
    logic          out_acc_reg, out_last_reg;
    logic [15:0]   out_cp_reg;

    // letter RAM
    logic                ram_we;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic          s_fire, m_fire, full;
    logic [CW-1:0] idx_inc;
    logic [IW-1:0] last_idx;
    logic [31:0]   count_ext;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign full     = count_reg >= CW'(MAX_LETTERS);
    assign idx_inc  = idx_reg + CW'(1);
    assign last_idx = IW'(count_reg - CW'(1));

    vkc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LETTERS)
    ) u_letters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        KIND_KEY:    state_next = (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                        KIND_READ,
                        KIND_COMMIT: state_next = (count_reg == '0) ? S_OUT : S_EMIT_RD;
                        default:     state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV: state_next = (idx_inc == count_reg) ? S_DECIDE : S_SCAN_RD;
            S_DECIDE:
            begin
                if (!d_acc)
                    state_next = S_OUT;
                else if (d_mod_en)
                    state_next = S_MOD_RD;
                else
                    state_next = S_PUSH;
            end
            S_MOD_RD:  state_next = S_MOD_WR;
            S_MOD_WR:  state_next = push_en_reg ? S_PUSH : S_OUT;
            S_PUSH:    state_next = S_OUT;
            S_EMIT_RD: state_next = S_EMIT_CV;
            S_EMIT_CV: state_next = S_OUT;
            S_OUT:
            begin
                if (m_tready)
                    state_next = out_last_reg ? S_IDLE : S_EMIT_RD;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs and RAM controls
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = mod_idx_reg;
        ram_raddr = idx_reg[IW-1:0];
        ram_wdata = ram_rdata;
        case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_MOD_RD: ram_raddr = mod_idx_reg;
            S_MOD_WR:
            begin
                ram_we = 1'b1;
                case (mod_op_reg)
                    MOD_SET_DIA:  ram_wdata[9:7] = mod_val_reg;
                    MOD_TGL_DIA:  ram_wdata[9:7] =
                                      (ram_rdata[9:7] == mod_val_reg) ? DIA_NONE : mod_val_reg;
                    MOD_TGL_TONE: ram_wdata[12:10] =
                                      (ram_rdata[12:10] == mod_val_reg) ? 3'd0 : mod_val_reg;
                    default:      ram_wdata = ram_rdata;
                endcase
            end
            S_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[IW-1:0];
                ram_wdata = {4'd0, push_dia_reg, push_base_reg};
            end
            S_OUT:    m_tvalid = 1'b1;
            default:  ;
        endcase
    end

    // Decision from the scan summary
    always_comb
    begin
        logic [6:0]    lk;
        logic [6:0]    last_low;
        logic          hv, done, tone_key;
        logic [2:0]    tone_val;
        logic [IW-1:0] tgt;

        lk       = to_low(key_reg);
        last_low = to_low(last_base_reg);
        hv       = vcnt_reg != 2'd0;
        done     = 1'b0;

        // tone placement: marked vowel, single vowel, qu cluster, final consonant
        if (mk_v_reg)
            tgt = mk_idx_reg;
        else if (vcnt_reg == 2'd1)
            tgt = pos0_reg;
        else if (qu_reg)
            tgt = (vcnt_reg == 2'd2) ? pos1_reg : (fc_reg ? posl_reg : pos1_reg);
        else
            tgt = fc_reg ? pos1_reg : pos0_reg;

        tone_key = 1'b1;
        case (lk)
            CH_S:    tone_val = 3'd1;
            CH_F:    tone_val = 3'd2;
            CH_R:    tone_val = 3'd3;
            CH_X:    tone_val = 3'd4;
            CH_J:    tone_val = 3'd5;
            CH_Z:    tone_val = 3'd0;
            default:
            begin
                tone_val = 3'd0;
                tone_key = 1'b0;
            end
        endcase

        d_acc       = 1'b0;
        d_mod_en    = 1'b0;
        d_mod_idx   = tgt;
        d_mod_op    = MOD_TGL_TONE;
        d_mod_val   = tone_val;
        d_push_en   = 1'b0;
        d_push_base = key_reg;
        d_push_dia  = DIA_NONE;

        if (!method_reg)
        begin
            if (hv && tone_key)
            begin
                d_acc    = 1'b1;
                d_mod_en = 1'b1;
                done     = 1'b1;
            end
            if (!done && (lk == CH_A || lk == CH_E || lk == CH_O) &&
                count_reg != '0 && last_low == lk)
            begin
                if (last_dia_reg == DIA_NONE)
                begin
                    d_acc = 1'b1; d_mod_en = 1'b1; d_mod_idx = last_idx;
                    d_mod_op = MOD_SET_DIA; d_mod_val = DIA_CIRC; done = 1'b1;
                end
                else if (last_dia_reg == DIA_CIRC)
                begin
                    done = 1'b1;
                    d_acc = !full; d_mod_en = 1'b1; d_push_en = 1'b1;
                    d_mod_idx = last_idx; d_mod_op = MOD_SET_DIA; d_mod_val = DIA_NONE;
                end
            end
            if (!done && lk == CH_W)
            begin
                if (w_v_reg)
                begin
                    d_acc = 1'b1; d_mod_en = 1'b1; d_mod_idx = w_idx_reg;
                    d_mod_op = MOD_TGL_DIA; d_mod_val = w_dia_reg; done = 1'b1;
                end
                else if (count_reg == '0 || !is_vowel(last_base_reg))
                begin
                    // standalone w becomes u with horn
                    done = 1'b1; d_acc = !full; d_push_en = 1'b1;
                    d_push_base = is_upper(key_reg) ? CH_UU : CH_U;
                    d_push_dia  = DIA_HORN;
                end
            end
            if (!done && lk == CH_D && count_reg != '0 && last_low == CH_D)
            begin
                if (last_dia_reg == DIA_NONE)
                begin
                    d_acc = 1'b1; d_mod_en = 1'b1; d_mod_idx = last_idx;
                    d_mod_op = MOD_SET_DIA; d_mod_val = DIA_STROKE; done = 1'b1;
                end
                else if (last_dia_reg == DIA_STROKE)
                begin
                    done = 1'b1;
                    d_acc = !full; d_mod_en = 1'b1; d_push_en = 1'b1;
                    d_mod_idx = last_idx; d_mod_op = MOD_SET_DIA; d_mod_val = DIA_NONE;
                end
            end
            if (!done && is_alpha(key_reg) && !full)
            begin
                d_acc = 1'b1; d_push_en = 1'b1;
            end
        end
        else
        begin
            if (key_reg >= CH_0 && key_reg <= CH_9)
            begin
                d_mod_en = 1'b1;
                d_mod_op = MOD_TGL_DIA;
                if (count_reg == '0)
                    d_acc = 1'b0;
                else if (key_reg <= CH_5)
                begin
                    d_acc     = hv;
                    d_mod_op  = MOD_TGL_TONE;
                    d_mod_val = 3'(key_reg - CH_0);
                end
                else if (key_reg == CH_6)
                begin
                    d_acc = circ_v_reg; d_mod_idx = circ_idx_reg; d_mod_val = DIA_CIRC;
                end
                else if (key_reg == CH_7)
                begin
                    d_acc = horn_v_reg; d_mod_idx = horn_idx_reg; d_mod_val = DIA_HORN;
                end
                else if (key_reg == CH_8)
                begin
                    d_acc = brev_v_reg; d_mod_idx = brev_idx_reg; d_mod_val = DIA_BREVE;
                end
                else
                begin
                    d_acc = dd_v_reg; d_mod_idx = dd_idx_reg; d_mod_val = DIA_STROKE;
                end
            end
            else if (is_alpha(key_reg) && !full)
            begin
                d_acc = 1'b1; d_push_en = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            method_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                method_reg <= cfg_wdata;
            if (s_fire && (s_tuser == KIND_COMMIT || s_tuser == KIND_CLEAR))
                count_reg <= '0;
            else if (state_reg == S_PUSH)
                count_reg <= count_reg + CW'(1);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        logic [6:0]    b, l;
        logic [2:0]    dia;
        logic [IW-1:0] i;
        logic          v;
        b   = ram_rdata[6:0];
        l   = to_low(b);
        dia = ram_rdata[9:7];
        i   = idx_reg[IW-1:0];
        v   = is_vowel(b);
        case (state_reg)
            S_IDLE:
            begin
                kind_reg     <= s_tuser;
                key_reg      <= s_tdata[6:0];
                emit_n_reg   <= count_reg;
                idx_reg      <= '0;
                vcnt_reg     <= 2'd0;
                mk_v_reg     <= 1'b0;
                fc_reg       <= 1'b0;
                qu_reg       <= 1'b0;
                w_v_reg      <= 1'b0;
                circ_v_reg   <= 1'b0;
                horn_v_reg   <= 1'b0;
                brev_v_reg   <= 1'b0;
                dd_v_reg     <= 1'b0;
                out_acc_reg  <= 1'b1;
                out_cp_reg   <= 16'd0;
                out_last_reg <= 1'b1;
            end
            S_SCAN_EV:
            begin
                if (v)
                begin
                    if (vcnt_reg == 2'd0)
                    begin
                        pos0_reg <= i;
                        qu_reg   <= (idx_reg != '0) && (prev_low_reg == CH_Q) && (l == CH_U);
                    end
                    if (vcnt_reg == 2'd1)
                        pos1_reg <= i;
                    posl_reg <= i;
                    if (vcnt_reg != 2'd3)
                        vcnt_reg <= vcnt_reg + 2'd1;
                    if (dia != DIA_NONE)
                    begin
                        mk_v_reg   <= 1'b1;
                        mk_idx_reg <= i;
                    end
                    fc_reg <= 1'b0;
                end
                else
                begin
                    fc_reg <= 1'b1;
                end
                // w target: nearest u, o or a reached through vowels only
                if (l == CH_U || l == CH_O)
                begin
                    w_v_reg <= 1'b1; w_idx_reg <= i; w_dia_reg <= DIA_HORN;
                end
                else if (l == CH_A)
                begin
                    w_v_reg <= 1'b1; w_idx_reg <= i; w_dia_reg <= DIA_BREVE;
                end
                else if (!v)
                begin
                    w_v_reg <= 1'b0;
                end
                if (l == CH_A || l == CH_E || l == CH_O)
                begin
                    circ_v_reg <= 1'b1; circ_idx_reg <= i;
                end
                if (l == CH_O || l == CH_U)
                begin
                    horn_v_reg <= 1'b1; horn_idx_reg <= i;
                end
                if (l == CH_A)
                begin
                    brev_v_reg <= 1'b1; brev_idx_reg <= i;
                end
                if (l == CH_D)
                begin
                    dd_v_reg <= 1'b1; dd_idx_reg <= i;
                end
                prev_low_reg  <= l;
                last_base_reg <= b;
                last_dia_reg  <= dia;
                idx_reg       <= idx_inc;
            end
            S_DECIDE:
            begin
                out_acc_reg   <= d_acc;
                mod_en_reg    <= d_mod_en;
                mod_idx_reg   <= d_mod_idx;
                mod_op_reg    <= d_mod_op;
                mod_val_reg   <= d_mod_val;
                push_en_reg   <= d_push_en;
                push_base_reg <= d_push_base;
                push_dia_reg  <= d_push_dia;
            end
            S_EMIT_CV:
            begin
                out_acc_reg  <= 1'b1;
                out_cp_reg   <= glyph_code(b, dia, ram_rdata[12:10]);
                out_last_reg <= idx_inc == emit_n_reg;
            end
            S_OUT:
            begin
                if (m_tready && !out_last_reg)
                    idx_reg <= idx_inc;
            end
            default: ;
        endcase
    end

    assign count_ext = 32'(count_reg);
    assign m_tdata   = {2'b00, count_ext[4:0], out_cp_reg, out_acc_reg};
    assign m_tlast   = out_last_reg;

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LETTERS))
        else $error("letter count beyond capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> !full)
        else $error("append into a full buffer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("ready while an item is in work");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_tlast) |=> s_tready)
        else $error("not idle after last word");

    a_mod_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD_RD) |-> (mod_en_reg && kind_reg == KIND_KEY))
        else $error("letter update without a key decision");

endmodule

FILE: rtl/core/vkc_ram.sv
// ----------------------------------------------------------------------------
// vkc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vkc_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: dv/vietnamese_key_composer_core_test.sv
// ============================================================================
// vietnamese_key_composer_core_test: self-checking bench for the key composer
// Drives key, read, commit and clear words under both input methods, predicts
// every result word with an independent composer model and compares them in
// order, with random gaps on both stream sides and a long output hold-off.
// ============================================================================
module vietnamese_key_composer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vkc_pkg::*;

    localparam int NUM_RANDOM = 240;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] key;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] code_point;
        logic [4:0]  count;
        logic        last;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    vietnamese_key_composer_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor state: letters held as base, diacritic, tone
    logic [6:0] sy_base [MAX_LETTERS_DEF];
    logic [2:0] sy_dia  [MAX_LETTERS_DEF];
    logic [2:0] sy_tone [MAX_LETTERS_DEF];
    int         sy_len;
    logic       vni_mode;

    cmd_t  pending_cmds[$];
    word_t expected_words[$];
    int    errors;
    int    words_seen;
    int    keys_sent;
    int    hold_off;
    int    idle_cycles;
    int    hold_reqs;
    int    hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic lc(input logic [6:0] c);
        return c >= 7'h61 && c <= 7'h7a;
    endfunction

    function automatic logic [6:0] low_of(input logic [6:0] c);
        return (c >= 7'h41 && c <= 7'h5a) ? c + 7'h20 : c;
    endfunction

    function automatic logic vowel(input logic [6:0] c);
        logic [6:0] l;
        l = low_of(c);
        return l == CH_A || l == CH_E || l == CH_I || l == CH_O || l == CH_U || l == CH_Y;
    endfunction

    function automatic logic any_vowel();
        for (int i = 0; i < sy_len; i++)
            if (vowel(sy_base[i])) return 1'b1;
        return 1'b0;
    endfunction

    // pick the vowel that carries the tone
    function automatic int tone_slot();
        int pos[MAX_LETTERS_DEF];
        int n;
        int marked;
        logic fc;
        n = 0;
        marked = -1;
        fc = 1'b0;
        for (int i = 0; i < sy_len; i++)
            if (vowel(sy_base[i]))
            begin
                pos[n] = i;
                n++;
                if (sy_dia[i] != DIA_NONE) marked = i;
            end
        if (n == 0) return -1;
        if (marked >= 0) return marked;
        if (n == 1) return pos[0];
        for (int i = pos[n-1] + 1; i < sy_len; i++)
            if (!vowel(sy_base[i]))
            begin
                fc = 1'b1;
                break;
            end
        if (pos[0] > 0 && low_of(sy_base[pos[0]-1]) == CH_Q && low_of(sy_base[pos[0]]) == CH_U)
        begin
            if (n == 2) return pos[1];
            return fc ? pos[n-1] : pos[1];
        end
        return fc ? pos[1] : pos[0];
    endfunction

    function automatic logic mark_tone(input logic [2:0] t);
        int p;
        p = tone_slot();
        if (p < 0) return 1'b0;
        sy_tone[p] = (sy_tone[p] == t) ? 3'd0 : t;
        return 1'b1;
    endfunction

    function automatic void append(input logic [6:0] b, input logic [2:0] d);
        sy_base[sy_len] = b;
        sy_dia[sy_len]  = d;
        sy_tone[sy_len] = 3'd0;
        sy_len++;
    endfunction

    function automatic logic flip_dia(input int i, input logic [2:0] d);
        sy_dia[i] = (sy_dia[i] == d) ? DIA_NONE : d;
        return 1'b1;
    endfunction

    function automatic logic vni_mark(input logic [2:0] d);
        logic [6:0] l;
        for (int i = sy_len - 1; i >= 0; i--)
        begin
            l = low_of(sy_base[i]);
            if (!vowel(l)) continue;
            if ((d == DIA_CIRC && (l == CH_A || l == CH_E || l == CH_O)) ||
                (d == DIA_BREVE && l == CH_A) || (d == DIA_HORN && (l == CH_O || l == CH_U)))
                return flip_dia(i, d);
        end
        return 1'b0;
    endfunction

    function automatic logic telex_press(input logic [6:0] k);
        logic [6:0] lk;
        logic [6:0] bl;
        int t;
        int j;
        lk = low_of(k);
        j = sy_len - 1;
        if (any_vowel())
        begin
            case (lk)
                CH_S: t = 1;
                CH_F: t = 2;
                CH_R: t = 3;
                CH_X: t = 4;
                CH_J: t = 5;
                CH_Z: t = 0;
                default: t = -1;
            endcase
            if (t >= 0 && mark_tone(3'(t))) return 1'b1;
        end
        if ((lk == CH_A || lk == CH_E || lk == CH_O) && sy_len > 0 && low_of(sy_base[j]) == lk)
        begin
            if (sy_dia[j] == DIA_NONE)
            begin
                sy_dia[j] = DIA_CIRC;
                return 1'b1;
            end
            if (sy_dia[j] == DIA_CIRC)
            begin
                if (sy_len >= MAX_LETTERS_DEF) return 1'b0;
                sy_dia[j] = DIA_NONE;
                append(k, DIA_NONE);
                return 1'b1;
            end
        end
        if (lk == CH_W)
        begin
            for (int i = sy_len - 1; i >= 0; i--)
            begin
                bl = low_of(sy_base[i]);
                if (bl == CH_U || bl == CH_O) return flip_dia(i, DIA_HORN);
                if (bl == CH_A) return flip_dia(i, DIA_BREVE);
                if (!vowel(bl)) break;
            end
            if (sy_len == 0 || !vowel(sy_base[j]))
            begin
                if (sy_len >= MAX_LETTERS_DEF) return 1'b0;
                append(lc(k) ? CH_U : CH_UU, DIA_HORN);
                return 1'b1;
            end
        end
        if (lk == CH_D && sy_len > 0 && low_of(sy_base[j]) == CH_D)
        begin
            if (sy_dia[j] == DIA_NONE)
            begin
                sy_dia[j] = DIA_STROKE;
                return 1'b1;
            end
            if (sy_dia[j] == DIA_STROKE)
            begin
                if (sy_len >= MAX_LETTERS_DEF) return 1'b0;
                sy_dia[j] = DIA_NONE;
                append(k, DIA_NONE);
                return 1'b1;
            end
        end
        if (lk >= CH_A && lk <= CH_Z && sy_len < MAX_LETTERS_DEF)
        begin
            append(k, DIA_NONE);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic vni_press(input logic [6:0] k);
        if (k >= CH_0 && k <= CH_9)
        begin
            if (sy_len == 0) return 1'b0;
            if (k <= CH_5) return any_vowel() && mark_tone(3'(k - CH_0));
            if (k == CH_6) return vni_mark(DIA_CIRC);
            if (k == CH_7) return vni_mark(DIA_HORN);
            if (k == CH_8) return vni_mark(DIA_BREVE);
            for (int i = sy_len - 1; i >= 0; i--)
                if (low_of(sy_base[i]) == CH_D) return flip_dia(i, DIA_STROKE);
            return 1'b0;
        end
        if (low_of(k) >= CH_A && low_of(k) <= CH_Z && sy_len < MAX_LETTERS_DEF)
        begin
            append(k, DIA_NONE);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // code point of one held letter, written from the glyph rows
    function automatic logic [15:0] letter_code(input int i);
        logic [6:0]  b;
        logic [15:0] row[6];
        logic        hit;
        b = sy_base[i];
        hit = 1'b1;
        case ({low_of(b), sy_dia[i]})
            {CH_A, DIA_NONE}:  row = '{16'h61, 16'he1, 16'he0, 16'h1ea3, 16'he3, 16'h1ea1};
            {CH_A, DIA_CIRC}:  row = '{16'he2, 16'h1ea5, 16'h1ea7, 16'h1ea9, 16'h1eab, 16'h1ead};
            {CH_A, DIA_BREVE}: row = '{16'h103, 16'h1eaf, 16'h1eb1, 16'h1eb3, 16'h1eb5, 16'h1eb7};
            {CH_E, DIA_NONE}:  row = '{16'h65, 16'he9, 16'he8, 16'h1ebb, 16'h1ebd, 16'h1eb9};
            {CH_E, DIA_CIRC}:  row = '{16'hea, 16'h1ebf, 16'h1ec1, 16'h1ec3, 16'h1ec5, 16'h1ec7};
            {CH_I, DIA_NONE}:  row = '{16'h69, 16'hed, 16'hec, 16'h1ec9, 16'h129, 16'h1ecb};
            {CH_O, DIA_NONE}:  row = '{16'h6f, 16'hf3, 16'hf2, 16'h1ecf, 16'hf5, 16'h1ecd};
            {CH_O, DIA_CIRC}:  row = '{16'hf4, 16'h1ed1, 16'h1ed3, 16'h1ed5, 16'h1ed7, 16'h1ed9};
            {CH_O, DIA_HORN}:  row = '{16'h1a1, 16'h1edb, 16'h1edd, 16'h1edf, 16'h1ee1, 16'h1ee3};
            {CH_U, DIA_NONE}:  row = '{16'h75, 16'hfa, 16'hf9, 16'h1ee7, 16'h169, 16'h1ee5};
            {CH_U, DIA_HORN}:  row = '{16'h1b0, 16'h1ee9, 16'h1eeb, 16'h1eed, 16'h1eef, 16'h1ef1};
            {CH_Y, DIA_NONE}:  row = '{16'h79, 16'hfd, 16'h1ef3, 16'h1ef7, 16'h1ef9, 16'h1ef5};
            {CH_D, DIA_STROKE}: row = '{default: 16'h111};
            default:           hit = 1'b0;
        endcase
        if (!hit || sy_tone[i] > 3'd5) return {9'd0, b};
        if (lc(b) || !(b >= 7'h41 && b <= 7'h5a)) return row[sy_tone[i]];
        return (row[sy_tone[i]] < 16'h100) ? row[sy_tone[i]] - 16'h20 : row[sy_tone[i]] - 16'h1;
    endfunction

    // compose one accepted command word and queue the results it causes
    function automatic void compose(input cmd_t c);
        word_t w;
        int    n;
        w = '0;
        w.last = 1'b1;
        if (c.kind == KIND_KEY || c.kind == KIND_CLEAR)
        begin
            if (c.kind == KIND_KEY) w.accepted = vni_mode ? vni_press(c.key) : telex_press(c.key);
            else
            begin
                w.accepted = 1'b1;
                sy_len = 0;
            end
            w.count = 5'(sy_len);
            expected_words = {expected_words, w};
            return;
        end
        n = sy_len;
        if (c.kind == KIND_COMMIT) sy_len = 0;
        w.accepted = 1'b1;
        w.count = 5'(sy_len);
        if (n == 0)
        begin
            expected_words = {expected_words, w};
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            w.code_point = letter_code(k);
            w.last = (k + 1 == n);
            expected_words = {expected_words, w};
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error word %0d: %s got %0h want %0h", words_seen, what, got, want);
        errors++;
    endtask

    // driver: hold the word until accepted, then advance after a random gap
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (s_tvalid && s_tready)
        begin
            compose(pending_cmds.pop_front());
            keys_sent++;
            send_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid && send_gap > 0)
            send_gap <= send_gap - 1;
        else if (!s_tvalid && pending_cmds.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_cmds[0].kind;
            s_tdata  <= {1'b0, pending_cmds[0].key};
        end
    end

    // monitor: compare each accepted result word with the oldest prediction
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        word_t got;
        word_t want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            hold_off  <= 0;
            hold_done <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[0], m_tdata[16:1], m_tdata[21:17], m_tlast};
                words_seen++;
                if (expected_words.size() == 0) report("unexpected word", 32'(got), 32'(0));
                else
                begin
                    want = expected_words.pop_front();
                    if (got.accepted != want.accepted)
                        report("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.code_point != want.code_point)
                        report("code_point", 32'(got.code_point), 32'(want.code_point));
                    if (got.count != want.count)
                        report("letter_count", 32'(got.count), 32'(want.count));
                    if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
                end
            end
            if (hold_reqs != hold_done)
            begin
                m_tready  <= 1'b0;
                hold_off  <= 300;
                hold_done <= hold_reqs;
            end
            else if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (m_tvalid && m_tready)
            begin
                recv_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
                recv_gap <= recv_gap - 1;
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: count cycles with no accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("vietnamese_key_composer_core: mismatch");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] kind, input logic [6:0] key);
        cmd_t c;
        c.kind = kind;
        c.key  = key;
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic type_text(input string s);
        for (int i = 0; i < s.len(); i++) push_cmd(KIND_KEY, 7'(s[i]));
    endtask

    // wait until everything is sent and answered, then set the method
    task automatic settle_and_set(input logic mode);
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_words.size() == 0);
        repeat (50) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        vni_mode  = mode;
    endtask

    // one random word: mostly plausible keys for the current method
    task automatic random_word(input logic mode);
        int r;
        string tel;
        string vni;
        tel = "aeiouydqwsfrxjzngtchAEOUWDSQ";
        vni = "aeiouydqnght0123456789AOUD";
        r = $urandom_range(0, 99);
        if (r < 5) push_cmd(KIND_READ, 7'($urandom));
        else if (r < 11) push_cmd(KIND_COMMIT, 7'($urandom));
        else if (r < 13) push_cmd(KIND_CLEAR, 7'($urandom));
        else if (r < 22) push_cmd(KIND_KEY, 7'($urandom));
        else if (mode) push_cmd(KIND_KEY, 7'(vni[$urandom_range(0, vni.len() - 1)]));
        else push_cmd(KIND_KEY, 7'(tel[$urandom_range(0, tel.len() - 1)]));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        vni_mode  = 1'b0;
        hold_reqs = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed Telex: empty read, standalone w, qu cluster, doubled marks
        push_cmd(KIND_READ, 7'h7f);
        type_text("w");
        push_cmd(KIND_COMMIT, 7'h00);
        type_text("quoocs");
        push_cmd(KIND_READ, 7'h00);
        type_text("DDaaaWj1");
        push_cmd(KIND_COMMIT, 7'h00);
        type_text("toanfz");
        push_cmd(KIND_CLEAR, 7'h55);
        // fill the buffer, then overflow it
        type_text("bcdfghklmnpqtvxz");
        type_text("b");
        push_cmd(KIND_COMMIT, 7'h00);
        type_text("aaaaaaaaaaaaaaaaaa");
        push_cmd(KIND_COMMIT, 7'h00);
        settle_and_set(1'b1);

        // directed VNI: digit marks, stroke, no-vowel tone
        type_text("1d9Duong7nh2");
        push_cmd(KIND_COMMIT, 7'h00);
        type_text("thuy8a6o61e0");
        push_cmd(KIND_READ, 7'h00);
        push_cmd(KIND_CLEAR, 7'h00);

        // random phases alternating methods; hold the output once mid-run
        for (int p = 0; p < 6; p++)
        begin
            settle_and_set(p[0]);
            if (p == 2) hold_reqs++;
            for (int i = 0; i < NUM_RANDOM / 6; i++) random_word(p[0]);
            push_cmd(KIND_COMMIT, 7'h00);
        end
        settle_and_set(1'b0);
        repeat (100) @(posedge clk);

        $display("covered %0d command words and %0d result words across Telex and VNI",
                 keys_sent, words_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("vietnamese_key_composer_core: match");
        else
            $display("vietnamese_key_composer_core: mismatch");
        $finish;
    end

endmodule

FILE: vietnamese_key_composer_core.f
rtl/core/vkc_pkg.sv
rtl/core/vkc_ram.sv
rtl/core/vietnamese_key_composer_core.sv
dv/vietnamese_key_composer_core_test.sv
